// ===== rtl/core/cosine_sum_window_generator_top_macros.svh =====
// Assertion macros shared by the cosine-sum window generator RTL.
`ifndef COSINE_SUM_WINDOW_GENERATOR_TOP_MACROS_SVH
`define COSINE_SUM_WINDOW_GENERATOR_TOP_MACROS_SVH

// Condition implies property in the same cycle.
`define CSWG_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("cswg: same-cycle check failed");

// Condition implies property in the following cycle.
`define CSWG_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("cswg: next-cycle check failed");

`endif

// ===== rtl/core/cswg_pkg.sv =====
// Shared constants, widths and tables of the cosine-sum window generator.
package cswg_pkg;

   localparam int LEN_W          = 13;
   localparam int IDX_W          = 12;
   localparam int COEF_W         = 16;
   localparam int OUT_W          = 18;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;
   localparam int MAX_LENGTH_DEF = 4096;

   localparam int LANES        = 3;
   localparam int VAL_W        = 15;
   localparam int MAG_W        = VAL_W - 1;
   localparam int MOD_STEPS    = MAG_W;
   localparam int PHASE_W      = 24;
   localparam int PHASE_STEPS  = PHASE_W + 1;
   localparam int PREM_W       = LEN_W + 1;
   localparam int FRAC_W       = PHASE_W - 2;
   localparam int THETA_W      = 31;
   localparam int CORDIC_W     = 33;
   localparam int CORDIC_STEPS = 24;
   localparam int COS_W        = 17;
   localparam int PROD_W       = COEF_W + COS_W;
   localparam int SUM_W        = PROD_W + 2;
   localparam int FRAC_SHIFT   = 15;

   localparam int ST_FIX      = MOD_STEPS + 1;
   localparam int ST_PHASE    = ST_FIX + PHASE_STEPS;
   localparam int ST_THETA    = ST_PHASE + 1;
   localparam int ST_CORDIC   = ST_THETA + CORDIC_STEPS;
   localparam int ST_OUT      = ST_CORDIC + 3;
   localparam int PIPE_DEPTH  = ST_OUT + 1;

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ZERO     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_ONE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_TWO      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_THREE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTRED_MODE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PERIODIC_MODE = 3'd6;

   localparam logic [LEN_W-1:0]         RST_WINDOW_LENGTH = 13'd1024;
   localparam logic signed [COEF_W-1:0] RST_COEF_ZERO     = 16'sd11755;
   localparam logic signed [COEF_W-1:0] RST_COEF_ONE      = 16'sd16000;
   localparam logic signed [COEF_W-1:0] RST_COEF_TWO      = 16'sd4630;
   localparam logic signed [COEF_W-1:0] RST_COEF_THREE    = 16'sd383;

   localparam logic [LEN_W-1:0]            LEN_MIN     = 13'd2;
   localparam logic [THETA_W-1:0]          HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [CORDIC_W-1:0]  GAIN_Q30    = 33'sd652032874;
   localparam logic signed [CORDIC_W-1:0]  COS_HALF    = 33'sd16384;
   localparam logic signed [CORDIC_W-1:0]  COS_MAX     = 33'sd32768;
   localparam logic signed [CORDIC_W-1:0]  COS_MIN     = -33'sd32768;
   localparam logic signed [SUM_W-1:0]     SUM_HALF    = 35'sd16384;
   localparam logic [PHASE_STEPS-1:0]      PHASE_ONE   = 25'h1000000;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int step);
      logic signed [CORDIC_W-1:0] one;
      one = CORDIC_W'(1);
      case (step)
         0: return 33'sd843314857;
         1: return 33'sd497837829;
         2: return 33'sd263043837;
         3: return 33'sd133525159;
         4: return 33'sd67021687;
         5: return 33'sd33543516;
         6: return 33'sd16775851;
         7: return 33'sd8388437;
         8: return 33'sd4194283;
         9: return 33'sd2097149;
         default: return one <<< (30 - step);
      endcase
   endfunction

endpackage

// ===== rtl/core/cswg_div_cell.sv =====
// One restoring-division cell: shifts in one dividend bit and produces one quotient bit.
module cswg_div_cell #(
   parameter int W  = 13,
   parameter int QW = 14
) (
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  up_rem,
   input  logic [QW-1:0] up_acc,
   input  logic [W-1:0]  divisor,
   output logic [W-1:0]  rem_ff,
   output logic [QW-1:0] acc_ff
);

   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          take;
   logic [W-1:0]  rem_in;
   logic [QW-1:0] acc_in;

   always_comb begin
      trial  = {up_rem, up_acc[QW-1]};
      diff   = trial - {1'b0, divisor};
      take   = trial >= {1'b0, divisor};
      rem_in = take ? diff[W-1:0] : trial[W-1:0];
      acc_in = {up_acc[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/core/cswg_cordic_cell.sv =====
// One rotation step of the cosine CORDIC.
module cswg_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [cswg_pkg::CORDIC_W-1:0]   up_x,
   input  logic signed [cswg_pkg::CORDIC_W-1:0]   up_y,
   input  logic signed [cswg_pkg::CORDIC_W-1:0]   up_z,
   output logic signed [cswg_pkg::CORDIC_W-1:0]   x_ff,
   output logic signed [cswg_pkg::CORDIC_W-1:0]   y_ff,
   output logic signed [cswg_pkg::CORDIC_W-1:0]   z_ff
);

   localparam logic signed [cswg_pkg::CORDIC_W-1:0] ANGLE = cswg_pkg::atan_q30(STEP);

   logic signed [cswg_pkg::CORDIC_W-1:0] dx;
   logic signed [cswg_pkg::CORDIC_W-1:0] dy;
   logic signed [cswg_pkg::CORDIC_W-1:0] x_in;
   logic signed [cswg_pkg::CORDIC_W-1:0] y_in;
   logic signed [cswg_pkg::CORDIC_W-1:0] z_in;

   always_comb begin
      dx = up_y >>> STEP;
      dy = up_x >>> STEP;
      if (!up_z[cswg_pkg::CORDIC_W-1]) begin
         x_in = up_x - dx;
         y_in = up_y + dy;
         z_in = up_z - ANGLE;
      end else begin
         x_in = up_x + dx;
         y_in = up_y - dy;
         z_in = up_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

endmodule

// ===== rtl/core/cosine_sum_window_generator_top.sv =====
// Top level of the four-term cosine-sum window coefficient generator.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_sample_index (12 bit)
//   rsp      out        rsp_valid/rsp_ready  rsp_window_value (18 bit signed Q3.15)
//   csr      in         csr_write            csr_index, csr_wdata
//
// One transaction is accepted every cycle while rsp is not stalled; each result passes through
// 69 register stages, of which the first loads at the edge that accepts its request.
// The stages are set by the cell chains: 14 modulo cells, 25 phase division cells and
// 24 CORDIC cells per cosine lane, plus six registered stages around them.
// A stall on rsp freezes the whole pipeline; req_ready then falls in the same cycle.
// Synchronous reset clears the valid chain and loads the register defaults.
module cosine_sum_window_generator_top #(
   parameter int MAX_LENGTH = cswg_pkg::MAX_LENGTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cswg_pkg::IDX_W-1:0]           req_sample_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [cswg_pkg::OUT_W-1:0]    rsp_window_value,
   input  logic                                 csr_write,
   input  logic [cswg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cswg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int L  = cswg_pkg::LANES;
   localparam int LW = cswg_pkg::LEN_W;
   localparam int CW = cswg_pkg::CORDIC_W;
   localparam int SUM_W = cswg_pkg::SUM_W;

   logic [LW-1:0]                       len_ff;
   logic signed [cswg_pkg::COEF_W-1:0]  coef0_ff;
   logic signed [cswg_pkg::COEF_W-1:0]  coef1_ff;
   logic signed [cswg_pkg::COEF_W-1:0]  coef2_ff;
   logic signed [cswg_pkg::COEF_W-1:0]  coef3_ff;
   logic                                centred_ff;
   logic                                periodic_ff;

   logic                                en;
   logic [cswg_pkg::PIPE_DEPTH-1:0]     vld_ff;

   logic [LW-1:0]                       len_c;
   logic [LW-1:0]                       div_len;
   logic signed [cswg_pkg::VAL_W-1:0]   n_val;
   logic signed [cswg_pkg::VAL_W-1:0]   v_val [L];

   logic [cswg_pkg::MAG_W-1:0]          mag_ff [L];
   logic                                neg_ff [L];
   logic                                neg_dly_ff [L][cswg_pkg::MOD_STEPS];
   logic [LW-1:0]                       mod_rem [L][cswg_pkg::MOD_STEPS+1];
   logic [cswg_pkg::MAG_W-1:0]          mod_acc [L][cswg_pkg::MOD_STEPS+1];
   logic [LW-1:0]                       r_ff [L];

   logic [cswg_pkg::PREM_W-1:0]         ph_rem [L][cswg_pkg::PHASE_STEPS+1];
   logic [cswg_pkg::PHASE_STEPS-1:0]    ph_acc [L][cswg_pkg::PHASE_STEPS+1];
   logic [cswg_pkg::PREM_W-1:0]         ph_div;

   logic [cswg_pkg::THETA_W-1:0]        theta_ff [L];
   logic [1:0]                          quad_ff [L];
   logic [1:0]                          quad_dly_ff [L][cswg_pkg::CORDIC_STEPS];
   logic signed [CW-1:0]                cx [L][cswg_pkg::CORDIC_STEPS+1];
   logic signed [CW-1:0]                cy [L][cswg_pkg::CORDIC_STEPS+1];
   logic signed [CW-1:0]                cz [L][cswg_pkg::CORDIC_STEPS+1];

   logic signed [cswg_pkg::COS_W-1:0]   cos_ff [L];
   logic signed [cswg_pkg::PROD_W-1:0]  prod_ff [L];
   logic signed [cswg_pkg::COEF_W-1:0]  lane_coef [L];
   logic signed [cswg_pkg::OUT_W-1:0]   out_ff;
   logic signed [cswg_pkg::SUM_W-1:0]   sum_val;
   logic signed [cswg_pkg::SUM_W-1:0]   sum_rnd;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= cswg_pkg::RST_WINDOW_LENGTH;
         coef0_ff    <= cswg_pkg::RST_COEF_ZERO;
         coef1_ff    <= cswg_pkg::RST_COEF_ONE;
         coef2_ff    <= cswg_pkg::RST_COEF_TWO;
         coef3_ff    <= cswg_pkg::RST_COEF_THREE;
         centred_ff  <= 1'b0;
         periodic_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            cswg_pkg::REG_WINDOW_LENGTH: len_ff      <= csr_wdata[LW-1:0];
            cswg_pkg::REG_COEF_ZERO:     coef0_ff    <= $signed(csr_wdata);
            cswg_pkg::REG_COEF_ONE:      coef1_ff    <= $signed(csr_wdata);
            cswg_pkg::REG_COEF_TWO:      coef2_ff    <= $signed(csr_wdata);
            cswg_pkg::REG_COEF_THREE:    coef3_ff    <= $signed(csr_wdata);
            cswg_pkg::REG_CENTRED_MODE:  centred_ff  <= csr_wdata[0];
            cswg_pkg::REG_PERIODIC_MODE: periodic_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign en        = !vld_ff[cswg_pkg::ST_OUT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[cswg_pkg::ST_OUT];
   assign rsp_window_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[cswg_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   // Length clamp, divisor and the three phase multiples.
   always_comb begin
      if (len_ff < cswg_pkg::LEN_MIN) begin
         len_c = cswg_pkg::LEN_MIN;
      end else if (32'(len_ff) > MAX_LENGTH) begin
         len_c = LW'(MAX_LENGTH);
      end else begin
         len_c = len_ff;
      end
      div_len = periodic_ff ? len_c : len_c - LW'(1);
      n_val = $signed({{(cswg_pkg::VAL_W-cswg_pkg::IDX_W){1'b0}}, req_sample_index});
      if (centred_ff) begin
         n_val = n_val - $signed({{(cswg_pkg::VAL_W-LW+1){1'b0}}, len_c[LW-1:1]});
      end
      v_val[0] = n_val;
      v_val[1] = n_val <<< 1;
      v_val[2] = n_val + (n_val <<< 1);
      ph_div = {div_len, 1'b0};
   end

   assign lane_coef[0] = coef1_ff;
   assign lane_coef[1] = coef2_ff;
   assign lane_coef[2] = coef3_ff;

   for (genvar l = 0; l < L; l++) begin : g_lane
      logic signed [cswg_pkg::VAL_W-1:0] v_abs;
      logic [cswg_pkg::PHASE_W-1:0]      phase;
      logic [cswg_pkg::FRAC_W+cswg_pkg::THETA_W-1:0] theta_full;
      logic signed [CW-1:0]              c_sel;
      logic signed [CW-1:0]              c_rnd;
      logic signed [cswg_pkg::COS_W-1:0] c_clamp;

      always_comb begin
         v_abs = v_val[l][cswg_pkg::VAL_W-1] ? -v_val[l] : v_val[l];
         phase = ph_acc[l][cswg_pkg::PHASE_STEPS][cswg_pkg::PHASE_W-1:0];
         theta_full = phase[cswg_pkg::FRAC_W-1:0] * cswg_pkg::HALF_PI_Q30;
         case (quad_dly_ff[l][cswg_pkg::CORDIC_STEPS-1])
            cswg_pkg::QUAD_0: c_sel = cx[l][cswg_pkg::CORDIC_STEPS];
            cswg_pkg::QUAD_1: c_sel = -cy[l][cswg_pkg::CORDIC_STEPS];
            cswg_pkg::QUAD_2: c_sel = -cx[l][cswg_pkg::CORDIC_STEPS];
            cswg_pkg::QUAD_3: c_sel = cy[l][cswg_pkg::CORDIC_STEPS];
            default:          c_sel = cx[l][cswg_pkg::CORDIC_STEPS];
         endcase
         c_rnd = (c_sel + cswg_pkg::COS_HALF) >>> cswg_pkg::FRAC_SHIFT;
         if (c_rnd > cswg_pkg::COS_MAX) begin
            c_clamp = cswg_pkg::COS_MAX[cswg_pkg::COS_W-1:0];
         end else if (c_rnd < cswg_pkg::COS_MIN) begin
            c_clamp = cswg_pkg::COS_MIN[cswg_pkg::COS_W-1:0];
         end else begin
            c_clamp = c_rnd[cswg_pkg::COS_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[l]   <= v_abs[cswg_pkg::MAG_W-1:0];
            neg_ff[l]   <= v_val[l][cswg_pkg::VAL_W-1];
            neg_dly_ff[l][0] <= neg_ff[l];
            for (int k = 1; k < cswg_pkg::MOD_STEPS; k++) begin
               neg_dly_ff[l][k] <= neg_dly_ff[l][k-1];
            end
            if (neg_dly_ff[l][cswg_pkg::MOD_STEPS-1] &&
                  mod_rem[l][cswg_pkg::MOD_STEPS] != '0) begin
               r_ff[l] <= div_len - mod_rem[l][cswg_pkg::MOD_STEPS];
            end else begin
               r_ff[l] <= mod_rem[l][cswg_pkg::MOD_STEPS];
            end
            theta_ff[l] <= theta_full[cswg_pkg::FRAC_W+cswg_pkg::THETA_W-1:cswg_pkg::FRAC_W];
            quad_ff[l]  <= phase[cswg_pkg::PHASE_W-1:cswg_pkg::PHASE_W-2];
            quad_dly_ff[l][0] <= quad_ff[l];
            for (int k = 1; k < cswg_pkg::CORDIC_STEPS; k++) begin
               quad_dly_ff[l][k] <= quad_dly_ff[l][k-1];
            end
            cos_ff[l]  <= c_clamp;
            prod_ff[l] <= lane_coef[l] * cos_ff[l];
         end
      end

      assign mod_rem[l][0] = '0;
      assign mod_acc[l][0] = mag_ff[l];
      for (genvar k = 0; k < cswg_pkg::MOD_STEPS; k++) begin : g_mod
         cswg_div_cell #(.W(LW), .QW(cswg_pkg::MAG_W)) u_cell (
            .clock   (clock),
            .en      (en),
            .up_rem  (mod_rem[l][k]),
            .up_acc  (mod_acc[l][k]),
            .divisor (div_len),
            .rem_ff  (mod_rem[l][k+1]),
            .acc_ff  (mod_acc[l][k+1])
         );
      end

      assign ph_rem[l][0] = {1'b0, r_ff[l]};
      assign ph_acc[l][0] = {{(cswg_pkg::PHASE_STEPS-LW){1'b0}}, div_len};
      for (genvar k = 0; k < cswg_pkg::PHASE_STEPS; k++) begin : g_phase
         cswg_div_cell #(.W(cswg_pkg::PREM_W), .QW(cswg_pkg::PHASE_STEPS)) u_cell (
            .clock   (clock),
            .en      (en),
            .up_rem  (ph_rem[l][k]),
            .up_acc  (ph_acc[l][k]),
            .divisor (ph_div),
            .rem_ff  (ph_rem[l][k+1]),
            .acc_ff  (ph_acc[l][k+1])
         );
      end

      assign cx[l][0] = cswg_pkg::GAIN_Q30;
      assign cy[l][0] = '0;
      assign cz[l][0] = $signed({{(CW-cswg_pkg::THETA_W){1'b0}}, theta_ff[l]});
      for (genvar k = 0; k < cswg_pkg::CORDIC_STEPS; k++) begin : g_cordic
         cswg_cordic_cell #(.STEP(k)) u_cell (
            .clock (clock),
            .en    (en),
            .up_x  (cx[l][k]),
            .up_y  (cy[l][k]),
            .up_z  (cz[l][k]),
            .x_ff  (cx[l][k+1]),
            .y_ff  (cy[l][k+1]),
            .z_ff  (cz[l][k+1])
         );
      end
   end

   // Weighted sum in Q5.30, rounded to Q3.15.
   always_comb begin
      sum_val = (SUM_W'(coef0_ff) <<< cswg_pkg::FRAC_SHIFT)
              - SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) - SUM_W'(prod_ff[2]);
      sum_rnd = (sum_val + cswg_pkg::SUM_HALF) >>> cswg_pkg::FRAC_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= sum_rnd[cswg_pkg::OUT_W-1:0];
      end
   end

`include "cosine_sum_window_generator_top_macros.svh"

   `CSWG_ASSERT_NEXT(a_stall_freezes_pipe, clock, reset, rsp_valid && !rsp_ready, $stable(vld_ff))
   `CSWG_ASSERT_NOW(a_mod_below_divisor, clock, reset, vld_ff[cswg_pkg::ST_FIX], r_ff[0] < div_len && r_ff[1] < div_len && r_ff[2] < div_len)
   `CSWG_ASSERT_NOW(a_phase_in_range, clock, reset, vld_ff[cswg_pkg::ST_PHASE], ph_acc[0][cswg_pkg::PHASE_STEPS] <= cswg_pkg::PHASE_ONE)

endmodule

// ===== tb/sv/tb_cosine_sum_window_generator_top.sv =====
// Self-checking testbench of the cosine-sum window generator with a bit-exact predictor.
module tb_cosine_sum_window_generator_top;

   localparam int LATENCY = 69;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1900;
   localparam logic [cswg_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {
      PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH
   } phase_type;

   typedef struct {
      logic [cswg_pkg::IDX_W-1:0] index;
      bit has_fixed;
      logic signed [cswg_pkg::OUT_W-1:0] fixed_value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cswg_pkg::IDX_W-1:0] req_sample_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [cswg_pkg::OUT_W-1:0] rsp_window_value;
   logic csr_write = 1'b0;
   logic [cswg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [cswg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [cswg_pkg::LEN_W-1:0] win_len;
   logic signed [cswg_pkg::COEF_W-1:0] a0, a1, a2, a3;
   bit centred, periodic;

   logic signed [cswg_pkg::OUT_W-1:0] expected_values[$];
   int errors = 0;
   int idle_cycles = 0;
   phase_type phase = PH_FREE;

   always #4 clock = ~clock;

   cosine_sum_window_generator_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_window_value(rsp_window_value),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cosine_q15(logic [23:0] p);
      longint z, x, y, a, dx, dy, c;
      longint atan_tab[10];
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149};
      z = (longint'(p[21:0]) * 64'd1686629713) >>> 22;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 24; i++) begin
         a = (i < 10) ? atan_tab[i] : (longint'(1) << (30 - i));
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      case (p[23:22])
         cswg_pkg::QUAD_0: c = x;
         cswg_pkg::QUAD_1: c = -y;
         cswg_pkg::QUAD_2: c = -x;
         default: c = y;
      endcase
      c = shift_floor(c + 16384, 15);
      if (c > 32768) c = 32768;
      if (c < -32768) c = -32768;
      return c;
   endfunction

   function automatic logic [23:0] turn_phase(longint v, longint d);
      longint r;
      r = v % d;
      if (r < 0) r += d;
      return 24'(((r << 25) + d) / (2 * d));
   endfunction

   function automatic logic signed [cswg_pkg::OUT_W-1:0] window_coefficient(
         logic [cswg_pkg::IDX_W-1:0] idx);
      longint len, n, d, s;
      len = win_len;
      if (len < 2) len = 2;
      if (len > cswg_pkg::MAX_LENGTH_DEF) len = cswg_pkg::MAX_LENGTH_DEF;
      d = periodic ? len : len - 1;
      n = idx;
      if (centred) n -= len / 2;
      s = longint'(a0) * 32768
        - longint'(a1) * cosine_q15(turn_phase(n, d))
        + longint'(a2) * cosine_q15(turn_phase(2 * n, d))
        - longint'(a3) * cosine_q15(turn_phase(3 * n, d));
      return cswg_pkg::OUT_W'(shift_floor(s + 16384, 15));
   endfunction

   task automatic write_csr(logic [cswg_pkg::CSR_IDX_W-1:0] idx,
                            logic [cswg_pkg::CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         cswg_pkg::REG_WINDOW_LENGTH: win_len = val[cswg_pkg::LEN_W-1:0];
         cswg_pkg::REG_COEF_ZERO: a0 = val;
         cswg_pkg::REG_COEF_ONE: a1 = val;
         cswg_pkg::REG_COEF_TWO: a2 = val;
         cswg_pkg::REG_COEF_THREE: a3 = val;
         cswg_pkg::REG_CENTRED_MODE: centred = val[0];
         cswg_pkg::REG_PERIODIC_MODE: periodic = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_index(logic [cswg_pkg::IDX_W-1:0] idx,
                             logic signed [cswg_pkg::OUT_W-1:0] exp_val);
      while ((phase == PH_SEND_IDLE && $urandom_range(99) < 84) ||
             (phase == PH_BOTH && $urandom_range(99) < 7)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_values.push_back(exp_val);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         case (phase)
            PH_RECV_STALL: rsp_ready <= ($urandom_range(99) >= 84);
            PH_BOTH: rsp_ready <= ($urandom_range(99) >= 7);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $display("%0t: unexpected result, actual %0d", $time, rsp_window_value);
            errors++;
         end else begin
            logic signed [cswg_pkg::OUT_W-1:0] want;
            want = expected_values.pop_front();
            if (want !== rsp_window_value) begin
               $display("%0t: window_value expected %0d actual %0d", $time, want,
                        rsp_window_value);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic random_settings(int sel);
      logic [cswg_pkg::CSR_DATA_W-1:0] len;
      case (sel)
         0: len = 2;
         1: len = 4096;
         2: len = 16'($urandom_range(8191));
         default: len = 16'($urandom_range(2, 300));
      endcase
      write_csr(cswg_pkg::REG_WINDOW_LENGTH, len);
      write_csr(cswg_pkg::REG_COEF_ZERO,
                (sel == 0) ? 16'h8000 : (sel == 1) ? 16'h7FFF : 16'($urandom));
      write_csr(cswg_pkg::REG_COEF_ONE,
                (sel == 0) ? 16'h7FFF : (sel == 1) ? 16'h8000 : 16'($urandom));
      write_csr(cswg_pkg::REG_COEF_TWO, (sel == 0) ? 16'h8000 : 16'($urandom));
      write_csr(cswg_pkg::REG_COEF_THREE, (sel == 1) ? 16'h8000 : 16'($urandom));
      write_csr(cswg_pkg::REG_CENTRED_MODE, 16'($urandom_range(1)));
      write_csr(cswg_pkg::REG_PERIODIC_MODE, 16'($urandom_range(1)));
      write_csr(REG_UNUSED, 16'($urandom));
   endtask

   initial begin
      stim_row_type rows[$];
      logic [cswg_pkg::IDX_W-1:0] idx;
      win_len = cswg_pkg::RST_WINDOW_LENGTH;
      a0 = cswg_pkg::RST_COEF_ZERO;
      a1 = cswg_pkg::RST_COEF_ONE;
      a2 = cswg_pkg::RST_COEF_TWO;
      a3 = cswg_pkg::RST_COEF_THREE;
      centred = 0;
      periodic = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Index zero after reset gives a0 - a1 + a2 - a3 = 2 exactly.
      rows.push_back('{12'd0, 1'b1, 18'sd2});
      rows.push_back('{12'd1023, 1'b1, 18'sd2});
      rows.push_back('{12'd4095, 1'b0, '0});
      rows.push_back('{12'd511, 1'b0, '0});
      rows.push_back('{12'd1024, 1'b0, '0});
      rows.push_back('{12'd2047, 1'b0, '0});
      rows.push_back('{12'hAAA, 1'b0, '0});
      rows.push_back('{12'h555, 1'b0, '0});
      foreach (rows[i])
         send_index(rows[i].index, rows[i].has_fixed ? rows[i].fixed_value
                                                     : window_coefficient(rows[i].index));
      drain();

      // Hann window, centred mode, and a length out of range.
      write_csr(cswg_pkg::REG_COEF_ZERO, 16'h4000);
      write_csr(cswg_pkg::REG_COEF_ONE, 16'h4000);
      write_csr(cswg_pkg::REG_COEF_TWO, 16'h0000);
      write_csr(cswg_pkg::REG_COEF_THREE, 16'h0000);
      write_csr(cswg_pkg::REG_PERIODIC_MODE, 16'd1);
      send_index(12'd0, 18'sd0);
      send_index(12'd512, 18'sd32768);
      drain();
      write_csr(cswg_pkg::REG_CENTRED_MODE, 16'd1);
      send_index(12'd0, window_coefficient(12'd0));
      send_index(12'd4095, window_coefficient(12'd4095));
      drain();
      write_csr(cswg_pkg::REG_WINDOW_LENGTH, 16'd0);
      send_index(12'd1, window_coefficient(12'd1));
      send_index(12'd4095, window_coefficient(12'd4095));
      drain();

      for (int p = 0; p < 8; p++) begin
         random_settings(p % 4);
         phase = phase_type'(p % 4);
         for (int i = 0; i < N_RANDOM / 8; i++) begin
            idx = ($urandom_range(3) == 0) ? 12'($urandom)
                                           : 12'($urandom_range(win_len + 2));
            send_index(idx, window_coefficient(idx));
         end
         drain();
      end

      phase = PH_FREE;
      drain();
      if (errors == 0 && expected_values.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
